// File: hw/rtl/wma_pkg.sv
`timescale 1ns / 1ps

package wma_pkg;

    localparam int DEPTH_DEF        = 16;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int FILL_W           = 5;
    localparam int CFG_W            = 5;

endpackage

// File: hw/rtl/wma_ring.sv
`timescale 1ns / 1ps

module wma_ring #(
    parameter int DEPTH  = 16,
    parameter int DATA_W = 16,
    parameter int IDX_W  = 4
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [IDX_W-1:0]  i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [IDX_W-1:0]  i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: hw/rtl/wma_div.sv
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module wma_div #(
    parameter int NUM_W = 21,
    parameter int DEN_W = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_q;
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   w_rem_sh;
    logic [DEN_W:0]   w_rem_sub;
    logic             w_ge;

    always_comb begin
        w_rem_sh  = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
        w_ge      = (w_rem_sh >= {1'b0, r_den});
        w_rem_sub = w_rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_rem_sub : w_rem_sh;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// File: hw/rtl/windowed_moving_average_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake                         Payload
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready  tdata: sample
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready  tdata: average, fill_level
// cfg       in   i_cfg_we                           i_cfg_wdata: window_length
//
// Each sample passes through the sequencer steps in order, paced by the bit-serial divider at
// one quotient bit per cycle: accept, ring read, sum update, magnitude, quotient bits,
// divider done, output load.
// Input ready only when the sequencer is idle; one result can wait in the output register.
// A stalled output holds the next finished result in the sequencer until the register frees.
// Reset (synchronous, active low) clears the window; ring contents are masked by fill count.
module windowed_moving_average_unit
    import wma_pkg::*;
#(
    parameter int DEPTH        = DEPTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [CFG_W-1:0]                        i_cfg_wdata,
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       i_s_axis_tdata, // sample
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    output logic [((SAMPLE_WIDTH+FILL_W+7)/8)*8-1:0] o_m_axis_tdata // average, fill_level
);

    localparam int OUT_W = ((SAMPLE_WIDTH + FILL_W + 7) / 8) * 8;
    localparam int CNT_W = ($clog2(DEPTH + 1) > FILL_W) ? $clog2(DEPTH + 1) : FILL_W;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W = SAMPLE_WIDTH + CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPD,
        S_MAG,
        S_DIV,
        S_HOLD
    } t_state;

    t_state                  r_state;
    logic [CNT_W-1:0]        r_window;
    logic [CNT_W-1:0]        r_fill;
    logic [CNT_W-1:0]        r_slot;
    logic signed [SUM_W-1:0] r_sum;
    logic [SAMPLE_WIDTH-1:0] r_sample;
    logic                    r_neg;
    logic [SAMPLE_WIDTH-1:0] r_avg;
    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out_data;

    logic [CNT_W-1:0]        w_slot;
    logic [CNT_W-1:0]        w_slot_inc;
    logic [CNT_W-1:0]        w_cfg_win;
    logic [SAMPLE_WIDTH-1:0] w_old;
    logic [SAMPLE_WIDTH-1:0] w_rd_data;
    logic signed [SUM_W-1:0] w_new_sum;
    logic [SUM_W-1:0]        w_mag;
    logic                    w_div_start;
    logic                    w_div_done;
    logic [SUM_W-1:0]        w_quot;
    logic [SUM_W-1:0]        w_quot_s;
    logic                    w_out_free;

    always_comb begin
        w_slot = ((r_slot >= r_window) || (r_slot >= CNT_W'(DEPTH))) ? '0 : r_slot;
        w_slot_inc = ((w_slot + 1'b1) >= r_window) ? '0 : w_slot + 1'b1;
        if (i_cfg_wdata == '0) begin
            w_cfg_win = CNT_W'(1);
        end else if (CNT_W'(i_cfg_wdata) > CNT_W'(DEPTH)) begin
            w_cfg_win = CNT_W'(DEPTH);
        end else begin
            w_cfg_win = CNT_W'(i_cfg_wdata);
        end
        // slots not yet written since the last clear read as zero
        w_old = (r_fill < r_window) ? '0 : w_rd_data;
        w_new_sum = r_sum - {{CNT_W{w_old[SAMPLE_WIDTH-1]}}, w_old}
                          + {{CNT_W{r_sample[SAMPLE_WIDTH-1]}}, r_sample};
        w_mag = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        w_quot_s = r_neg ? -w_quot : w_quot;
        w_out_free = !r_out_valid || i_m_axis_tready;
    end

    assign w_div_start = (r_state == S_MAG);

    wma_ring #(
        .DEPTH  (DEPTH),
        .DATA_W (SAMPLE_WIDTH),
        .IDX_W  (IDX_W)
    ) u_ring (
        .i_clk     (i_clk),
        .i_wr_en   (r_state == S_UPD),
        .i_wr_addr (w_slot[IDX_W-1:0]),
        .i_wr_data (r_sample),
        .i_rd_en   (r_state == S_READ),
        .i_rd_addr (w_slot[IDX_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    wma_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_mag),
        .i_den   (r_fill),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= CNT_W'(DEPTH);
            r_fill      <= '0;
            r_slot      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_HOLD && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_window <= w_cfg_win;
                r_fill   <= '0;
                r_slot   <= '0;
                r_sum    <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_sum   <= w_new_sum;
                    r_slot  <= w_slot_inc;
                    if (r_fill < r_window) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_state <= S_MAG;
                end
                S_MAG: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_s_axis_tvalid) begin
            r_sample <= i_s_axis_tdata[SAMPLE_WIDTH-1:0];
        end
        if (r_state == S_MAG) begin
            r_neg <= r_sum[SUM_W-1];
        end
        if (r_state == S_DIV && w_div_done) begin
            r_avg <= w_quot_s[SAMPLE_WIDTH-1:0];
        end
        if (r_state == S_HOLD && w_out_free) begin
            r_out_data <= OUT_W'({r_fill[FILL_W-1:0], r_avg});
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    a_fill_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_window)
        else $error("fill count above window length");

    a_slot_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot < r_window)
        else $error("write slot outside window");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && !i_cfg_we) |=> (r_state == S_READ))
        else $error("accepted request did not start a ring read");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside divide state");

    a_fill_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_fill != '0))
        else $error("divide by zero fill count");

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import wma_pkg::*;

    localparam int IN_W      = ((SAMPLE_WIDTH_DEF + 7) / 8) * 8;
    localparam int OUT_W     = ((SAMPLE_WIDTH_DEF + FILL_W + 7) / 8) * 8;
    localparam int HOLD_LEN  = 300;
    localparam int DRAIN_LEN = 40;
    localparam int LIMIT     = 400000;
    localparam int CHUNK     = 38;

    typedef logic signed [SAMPLE_WIDTH_DEF-1:0] t_sample;

    typedef struct packed {
        t_sample           avg;
        logic [FILL_W-1:0] fill;
    } t_avg_result;

    typedef struct packed {
        bit                is_cfg;
        logic [CFG_W-1:0]  cfg;
        t_sample           sample;
        bit                typed;
        t_avg_result       want;
    } t_steer_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [IN_W-1:0]      i_s_axis_tdata;   // [15:0] sample
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [OUT_W-1:0]     o_m_axis_tdata;   // [15:0] average, [20:16] fill_level

    windowed_moving_average_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // window model
    t_sample     win_ring [DEPTH_DEF];
    int          win_sum;
    int          win_slot;
    int          win_fill;
    int          win_len;

    t_avg_result pending_avgs [$];
    int          errors;
    int          cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_asked;
    int          hold_served;
    int          hold_left;

    function automatic void set_window(input logic [CFG_W-1:0] v);
        win_len = (v == 0) ? 1 : ((int'(v) > DEPTH_DEF) ? DEPTH_DEF : int'(v));
        foreach (win_ring[i]) win_ring[i] = '0;
        win_sum  = 0;
        win_slot = 0;
        win_fill = 0;
    endfunction

    function automatic t_avg_result advance_window(input t_sample s);
        t_avg_result r;
        int          slot;
        slot = win_slot;
        if (slot >= win_len) slot = 0;
        if (win_fill < win_len) win_fill++;
        win_sum = win_sum - int'(win_ring[slot]) + int'(s);
        win_ring[slot] = s;
        slot++;
        if (slot >= win_len) slot = 0;
        win_slot = slot;
        r.avg  = t_sample'(win_sum / win_fill);
        r.fill = FILL_W'(win_fill);
        return r;
    endfunction

    function automatic t_sample pick_sample();
        case ($urandom_range(7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return t_sample'(int'($urandom_range(15)) - 8);
            default: return t_sample'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task automatic offer_sample(input t_sample s, input bit typed, input t_avg_result want);
        t_avg_result r;
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_W'(s);
        do @(posedge i_clk); while (!o_s_axis_tready);
        r = advance_window(s);
        pending_avgs.push_back(typed ? want : r);
    endtask

    // only with the block drained
    task automatic write_window(input logic [CFG_W-1:0] v);
        i_s_axis_tvalid <= 1'b0;
        while (pending_avgs.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        set_window(v);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // receiver
    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asked != hold_served) begin
                hold_served = hold_asked;
                hold_left   = HOLD_LEN;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_avg_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_avgs.size() == 0) begin
                report_mismatch("unexpected average", $signed(o_m_axis_tdata[15:0]), 0);
            end else begin
                want = pending_avgs.pop_front();
                if (o_m_axis_tdata[15:0] !== want.avg)
                    report_mismatch("average", $signed(o_m_axis_tdata[15:0]), want.avg);
                if (o_m_axis_tdata[20:16] !== want.fill)
                    report_mismatch("fill_level", o_m_axis_tdata[20:16], want.fill);
            end
        end
    end

    // directed rows; a window write drains the block first
    t_steer_row steer_rows [23];
    logic [CFG_W-1:0] cfg_plan [12];

    initial begin
        t_avg_result none;
        int          ph;
        int          ch;
        int          k;

        none            = '0;
        errors          = 0;
        cycles          = 0;
        hold_asked      = 0;
        hold_served     = 0;
        hold_left       = 0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        set_window(CFG_W'(DEPTH_DEF));

        steer_rows[0]  = '{0, 0,  16'sh7FFF, 1, '{16'sh7FFF, 5'd1}};
        steer_rows[1]  = '{0, 0,  16'sh8000, 1, '{16'sh0000, 5'd2}};
        steer_rows[2]  = '{0, 0,  16'sh0000, 1, '{16'sh0000, 5'd3}};
        steer_rows[3]  = '{0, 0,  -16'sd1,   0, '0};
        steer_rows[4]  = '{1, 0,  16'sh0000, 0, '0};
        steer_rows[5]  = '{0, 0,  16'sh8000, 1, '{16'sh8000, 5'd1}};
        steer_rows[6]  = '{0, 0,  16'sh7FFF, 1, '{16'sh7FFF, 5'd1}};
        steer_rows[7]  = '{1, 2,  16'sh0000, 0, '0};
        steer_rows[8]  = '{0, 0,  -16'sd1,   1, '{-16'sd1,   5'd1}};
        steer_rows[9]  = '{0, 0,  -16'sd2,   1, '{-16'sd1,   5'd2}};
        steer_rows[10] = '{0, 0,  16'sd4,    1, '{16'sd1,    5'd2}};
        steer_rows[11] = '{1, 31, 16'sh0000, 0, '0};
        steer_rows[12] = '{0, 0,  16'sh5555, 0, '0};
        steer_rows[13] = '{0, 0,  16'shAAAA, 0, '0};
        steer_rows[14] = '{1, 16, 16'sh0000, 0, '0};
        steer_rows[15] = '{0, 0,  16'sh8000, 1, '{16'sh8000, 5'd1}};
        steer_rows[16] = '{0, 0,  16'sh8000, 1, '{16'sh8000, 5'd2}};
        steer_rows[17] = '{0, 0,  16'sd1,    0, '0};
        steer_rows[18] = '{1, 17, 16'sh0000, 0, '0};
        steer_rows[19] = '{0, 0,  16'sd100,  1, '{16'sd100,  5'd1}};
        steer_rows[20] = '{1, 1,  16'sh0000, 0, '0};
        steer_rows[21] = '{0, 0,  16'sd7,    1, '{16'sd7,    5'd1}};
        steer_rows[22] = '{0, 0,  -16'sd7,   1, '{-16'sd7,   5'd1}};

        cfg_plan = '{5'd0, 5'd16, 5'd5, 5'd31, 5'd1, 5'd17,
                     5'd3, 5'd16, 5'd8, 5'd2, 5'd15, 5'd9};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (steer_rows[i]) begin
            if (steer_rows[i].is_cfg)
                write_window(steer_rows[i].cfg);
            else
                offer_sample(steer_rows[i].sample, steer_rows[i].typed, steer_rows[i].want);
        end

        for (ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 26 : ((ph == 1) ? 56 : 0);
            recv_idle_pct = (ph == 0) ? 56 : ((ph == 1) ? 26 : 0);
            for (ch = 0; ch < 4; ch++) begin
                if (ph == 1 && ch == 3)
                    write_window(CFG_W'($urandom_range(31)));
                else
                    write_window(cfg_plan[ph * 4 + ch]);
                // long output stall while requests keep coming
                if (ph == 2 && ch == 1) hold_asked++;
                for (k = 0; k < CHUNK; k++)
                    offer_sample(pick_sample(), 1'b0, none);
            end
        end

        i_s_axis_tvalid <= 1'b0;
        while (pending_avgs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_LEN) @(posedge i_clk);

        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
